// ----- rtl/bdb_pkg.sv -----
// ----------------------------------------------------------------------------
// bdb_pkg: shared types and constants for the button debounce / blink block
// Register indexes, register reset values and the structs passed between
// the configuration, step and top-level modules.
// ----------------------------------------------------------------------------
package bdb_pkg;

   localparam int TIME_W     = 32;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TIME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_MODE    = 2'd2;

   localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST  = 16'd50;
   localparam logic [CFG_W-1:0] BLINK_INTERVAL_RST = 16'd500;

   localparam logic MODE_MOMENTARY = 1'b0;
   localparam logic MODE_BLINK     = 1'b1;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] blink_interval;
      logic             button_mode;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic value;
   } result_type;

endpackage

// ----- rtl/bdb_csr.sv -----
// ----------------------------------------------------------------------------
// bdb_csr: configuration registers
// Holds debounce time, blink interval and mode; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module bdb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bdb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdb_pkg::CFG_W-1:0]      csr_data,
   output bdb_pkg::cfg_type               cfg
);

   bdb_pkg::cfg_type cfg_ff;
   bdb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bdb_pkg::CSR_DEBOUNCE_TIME:  cfg_in.debounce_time  = csr_data;
            bdb_pkg::CSR_BLINK_INTERVAL: cfg_in.blink_interval = csr_data;
            bdb_pkg::CSR_BUTTON_MODE:    cfg_in.button_mode    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time  <= bdb_pkg::DEBOUNCE_TIME_RST;
         cfg_ff.blink_interval <= bdb_pkg::BLINK_INTERVAL_RST;
         cfg_ff.button_mode    <= bdb_pkg::MODE_MOMENTARY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/bdb_core.sv -----
// ----------------------------------------------------------------------------
// bdb_core: debounce and blink state with the per-sample step logic
// Evaluates one registered sample per enabled cycle and updates state.
// ----------------------------------------------------------------------------
module bdb_core (
   input  logic                          clock,
   input  logic                          reset,
   input  bdb_pkg::cfg_type              cfg,
   input  logic                          step_en,
   input  logic [bdb_pkg::TIME_W-1:0]    time_now,
   input  logic                          raw_level,
   output bdb_pkg::result_type           result
);

   logic                       last_raw_ff,     last_raw_in;
   logic                       stable_ff,       stable_in;
   logic [bdb_pkg::TIME_W-1:0] change_time_ff,  change_time_in;
   logic                       blink_on_ff,     blink_on_in;
   logic [bdb_pkg::TIME_W-1:0] toggle_time_ff,  toggle_time_in;

   logic [bdb_pkg::TIME_W-1:0] since_change;
   logic [bdb_pkg::TIME_W-1:0] since_toggle;
   logic                       settle;
   logic                       blink_due;

   always_comb begin
      last_raw_in    = raw_level;
      change_time_in = (raw_level != last_raw_ff) ? time_now : change_time_ff;
      stable_in      = stable_ff;
      blink_on_in    = blink_on_ff;
      toggle_time_in = toggle_time_ff;
      result         = '0;

      // modulo 2^32 elapsed time
      since_change = time_now - change_time_in;
      since_toggle = time_now - toggle_time_ff;
      settle = (since_change >= {{(bdb_pkg::TIME_W-bdb_pkg::CFG_W){1'b0}},
                                 cfg.debounce_time}) && (stable_ff != raw_level);

      if (settle) begin
         stable_in = raw_level;
         if (cfg.button_mode == bdb_pkg::MODE_MOMENTARY) begin
            result.valid = 1'b1;
            result.value = (raw_level == bdb_pkg::LEVEL_PRESSED);
         end else if (raw_level == bdb_pkg::LEVEL_RELEASED && blink_on_ff) begin
            blink_on_in  = 1'b0;
            result.valid = 1'b1;
            result.value = 1'b0;
         end
      end

      blink_due = (cfg.button_mode == bdb_pkg::MODE_BLINK) &&
                  (stable_in == bdb_pkg::LEVEL_PRESSED) &&
                  (since_toggle >= {{(bdb_pkg::TIME_W-bdb_pkg::CFG_W){1'b0}},
                                    cfg.blink_interval});
      if (blink_due) begin
         blink_on_in    = ~blink_on_in;
         toggle_time_in = time_now;
         result.valid   = 1'b1;
         result.value   = blink_on_in;
      end

      if (!step_en) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= bdb_pkg::LEVEL_RELEASED;
         stable_ff      <= bdb_pkg::LEVEL_RELEASED;
         change_time_ff <= '0;
         blink_on_ff    <= 1'b0;
         toggle_time_ff <= '0;
      end else if (step_en) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         blink_on_ff    <= blink_on_in;
         toggle_time_ff <= toggle_time_in;
      end
   end

   // a stable change always takes the level of the current sample
   assert property (@(posedge clock) disable iff (reset)
      step_en && (stable_in != stable_ff) |-> (stable_in == raw_level))
      else $error("stable level took a value other than the sample");

   // blink flag only set while pressed in blink mode
   assert property (@(posedge clock) disable iff (reset)
      step_en && !blink_on_ff && blink_on_in |->
         cfg.button_mode == bdb_pkg::MODE_BLINK && stable_in == bdb_pkg::LEVEL_PRESSED)
      else $error("blink flag set outside a held press");

   // an idle cycle changes no state
   assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(stable_ff) && $stable(blink_on_ff) && $stable(toggle_time_ff))
      else $error("state changed without a sample");

endmodule

// ----- rtl/button_debounce_blink.sv -----
// ----------------------------------------------------------------------------
// button_debounce_blink: timestamped push-button debounce with blink mode
// Registers each pin sample, runs one debounce/blink step on it and
// registers the reported value, if any.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   req     | in        | req_valid, req_ready, req_time_now, req_raw_level
//   rsp     | out       | rsp_valid, rsp_ready, rsp_send_value
//   csr     | in        | csr_valid, csr_ready, csr_index, csr_data
//
// One sample per cycle while rsp is not stalled. A sample waits in the input
// register until its step; its value, if any, is presented the cycle after that step.
// The step stage advances whenever the result register is empty or taken,
// so a stalled rsp holds one sample in the input register, then req_ready drops.
// Synchronous reset restores released-pin state, time zero and default registers.
// csr writes are accepted every cycle.
// ----------------------------------------------------------------------------
module button_debounce_blink (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bdb_pkg::TIME_W-1:0]    req_time_now,
   input  logic                          req_raw_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_send_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bdb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bdb_pkg::CFG_W-1:0]     csr_data
);

   bdb_pkg::cfg_type    cfg;
   bdb_pkg::result_type result;

   logic                       in_valid_ff, in_valid_in;
   logic [bdb_pkg::TIME_W-1:0] in_time_ff;
   logic                       in_raw_ff;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_value_ff;
   logic                       advance;

   bdb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bdb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (advance),
      .time_now  (in_time_ff),
      .raw_level (in_raw_ff),
      .result    (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_time_ff <= req_time_now;
         in_raw_ff  <= req_raw_level;
      end
      if (advance && result.valid) begin
         out_value_ff <= result.value;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_send_value = out_value_ff;

   // req is only held off by a full input register behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("req_ready low without a stall");

   // a held sample stays put until it is evaluated
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_time_ff) && $stable(in_raw_ff))
      else $error("input register lost a pending sample");

   // a new result only appears from a step
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("result presented without a step");

endmodule
